FILE: hw/rtl/bdp_pkg.sv
// shared types and constants for the byte delta patch decoder
// no dependencies; imported by every module of the block

package bdp_pkg;

   localparam int MAX_BLOCK = 65536;
   localparam int POS_W     = $clog2(MAX_BLOCK + 1);
   localparam int CSR_W     = 17;
   localparam int ACC_W     = 21;
   localparam int GRP_W     = 2;
   localparam int SUM_W     = ACC_W + 1;
   localparam int ADDR_W    = 16;

   // last LEB128 group; a continuation bit on this group is a format error
   localparam logic [GRP_W-1:0] LAST_GROUP = GRP_W'(2);

   typedef enum logic [3:0] {
      PH_SKIP    = 4'b0001,
      PH_LCOUNT  = 4'b0010,
      PH_LITERAL = 4'b0100,
      PH_DONE    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       start_new;
      logic [7:0] delta_byte;
   } req_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_address;
      logic [7:0]        write_data;
      logic              block_done;
      logic              format_error;
   } rsp_type;

   // input register contents handed to the decode stage
   typedef struct packed {
      logic    valid;
      req_type data;
   } stage_type;

   // decode result handed to the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

FILE: hw/rtl/byte_delta_patch_decoder_unit.sv
// Byte delta patch decoder: takes a delta stream one byte per transfer and
// turns literal bytes into buffer writes, marking block completion and format
// errors. Each accepted byte passes the input register, a combinational decode
// against the stream state, and the result register, so a byte is accepted
// every cycle and its result (if any) is presented on the result port from the
// result register; only a stall on the result side slows the input.
// block_size must be written while the stream is idle.
// depends on bdp_pkg, bdp_in_stage, bdp_decode, bdp_out_stage

module byte_delta_patch_decoder_unit
   import bdp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_write_enable,
   input  logic [CSR_W-1:0] csr_write_data
);

   logic [CSR_W-1:0] block_size_ff;
   logic [CSR_W-1:0] block_size_in;
   logic [POS_W-1:0] size;
   logic             take;
   stage_type        stage;
   result_type       result;

   assign block_size_in = csr_write_enable ? csr_write_data : block_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= CSR_W'(MAX_BLOCK);
      end else begin
         block_size_ff <= block_size_in;
      end
   end

   // effective size is limited to the largest supported buffer
   assign size = (32'(block_size_ff) > 32'(MAX_BLOCK)) ? POS_W'(MAX_BLOCK)
                                                        : POS_W'(block_size_ff);

   bdp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .take      (take),
      .stage     (stage)
   );

   bdp_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .take   (take),
      .size   (size),
      .result (result)
   );

   bdp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/bdp_in_stage.sv
// input register of the byte delta patch decoder
// depends on bdp_pkg

module bdp_in_stage
   import bdp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      take,
   output stage_type stage
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;

   // held item moves on whenever the decode stage can take it
   assign req_stall   = in_valid_ff && !take;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   assign stage.valid = in_valid_ff;
   assign stage.data  = in_data_ff;

endmodule

FILE: hw/rtl/bdp_decode.sv
// stream state and per-byte decode of the byte delta patch decoder
// depends on bdp_pkg

module bdp_decode
   import bdp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  stage_type        stage,
   input  logic             take,
   input  logic [POS_W-1:0] size,
   output result_type       result
);

   phase_type        phase_ff, phase_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] lit_ff, lit_in;
   logic             err_ff, err_in;

   phase_type        cur_phase;
   logic [ACC_W-1:0] cur_acc;
   logic [GRP_W-1:0] cur_grp;
   logic [POS_W-1:0] cur_pos;
   logic [POS_W-1:0] cur_lit;
   logic             cur_err;

   logic             go;
   logic [7:0]       byte_v;
   logic [ACC_W-1:0] acc_new;
   logic [SUM_W-1:0] end_sum;
   logic [POS_W-1:0] pos_inc;
   logic [POS_W-1:0] lit_dec;
   rsp_type          res;
   logic             res_valid;

   assign go     = stage.valid && take;
   assign byte_v = stage.data.delta_byte;

   // a start flag clears the stream before the byte is handled
   always_comb begin
      if (stage.data.start_new) begin
         cur_phase = PH_SKIP;
         cur_acc   = '0;
         cur_grp   = '0;
         cur_pos   = '0;
         cur_lit   = '0;
         cur_err   = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_acc   = acc_ff;
         cur_grp   = grp_ff;
         cur_pos   = pos_ff;
         cur_lit   = lit_ff;
         cur_err   = err_ff;
      end
   end

   // place the 7-bit group at its LEB128 position
   always_comb begin
      case (cur_grp)
         2'd0:    acc_new = cur_acc | {14'd0, byte_v[6:0]};
         2'd1:    acc_new = cur_acc | {7'd0, byte_v[6:0], 7'd0};
         2'd2:    acc_new = cur_acc | {byte_v[6:0], 14'd0};
         default: acc_new = cur_acc;
      endcase
   end

   assign end_sum = SUM_W'(cur_pos) + SUM_W'(acc_new);
   assign pos_inc = cur_pos + POS_W'(1);
   assign lit_dec = cur_lit - POS_W'(1);

   always_comb begin
      phase_in  = cur_phase;
      acc_in    = cur_acc;
      grp_in    = cur_grp;
      pos_in    = cur_pos;
      lit_in    = cur_lit;
      err_in    = cur_err;
      res_valid = 1'b0;
      res       = '0;
      if (cur_err || cur_phase == PH_DONE) begin
         // ignored until the next start flag
      end else if (cur_pos >= size) begin
         // buffer already covered: byte is dropped and block done is reported
         phase_in       = PH_DONE;
         res_valid      = 1'b1;
         res.block_done = 1'b1;
      end else begin
         case (cur_phase)
            PH_LITERAL: begin
               pos_in            = pos_inc;
               lit_in            = lit_dec;
               res_valid         = 1'b1;
               res.write_valid   = 1'b1;
               res.write_address = cur_pos[ADDR_W-1:0];
               res.write_data    = byte_v;
               if (pos_inc >= size) begin
                  phase_in       = PH_DONE;
                  res.block_done = 1'b1;
               end else if (lit_dec == '0) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP, PH_LCOUNT: begin
               acc_in = acc_new;
               if (byte_v[7]) begin
                  if (cur_grp >= LAST_GROUP) begin
                     err_in           = 1'b1;
                     res_valid        = 1'b1;
                     res.format_error = 1'b1;
                  end else begin
                     grp_in = cur_grp + GRP_W'(1);
                  end
               end else if (end_sum > SUM_W'(size)) begin
                  err_in           = 1'b1;
                  res_valid        = 1'b1;
                  res.format_error = 1'b1;
               end else begin
                  acc_in = '0;
                  grp_in = '0;
                  if (cur_phase == PH_SKIP) begin
                     pos_in = end_sum[POS_W-1:0];
                     if (end_sum == SUM_W'(size)) begin
                        phase_in       = PH_DONE;
                        res_valid      = 1'b1;
                        res.block_done = 1'b1;
                     end else begin
                        phase_in = PH_LCOUNT;
                     end
                  end else begin
                     // count fits the buffer, so it fits the position width
                     lit_in   = acc_new[POS_W-1:0];
                     phase_in = (acc_new == '0) ? PH_SKIP : PH_LITERAL;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         acc_ff   <= '0;
         grp_ff   <= '0;
         pos_ff   <= '0;
         lit_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (go) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         grp_ff   <= grp_in;
         pos_ff   <= pos_in;
         lit_ff   <= lit_in;
         err_ff   <= err_in;
      end
   end

   assign result.valid = go && res_valid;
   assign result.data  = res;

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && !(go && stage.data.start_new) |=> err_ff)
      else $error("error flag dropped without a start flag");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE && !(go && stage.data.start_new) |=> phase_ff == PH_DONE)
      else $error("done phase left without a start flag");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.data.write_valid |-> cur_pos < size)
      else $error("literal write beyond the buffer");

   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.data.format_error |=> err_ff)
      else $error("format error reported but not recorded");

endmodule

FILE: hw/rtl/bdp_out_stage.sv
// result register of the byte delta patch decoder
// depends on bdp_pkg

module bdp_out_stage
   import bdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       take,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // register is free when empty or its transfer completes this cycle
   assign take         = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = take ? result.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         rsp_data_ff <= result.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
